// ===== sv/sspc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, code bytes and arithmetic helpers for the serial setpoint
// command parser. No dependencies; every other file imports this package.
package sspc_pkg;

  typedef struct packed {
    logic       command;
    logic [7:0] rx_byte;
    logic [9:0] input_voltage;
    logic [9:0] process_value;
  } sspc_in_t;

  typedef struct packed {
    logic [7:0]  tx_byte;
    logic        last;
    logic [1:0]  write_target;
    logic [13:0] write_value;
    logic        integrator_clear;
    logic        led_level;
  } sspc_out_t;

  // Protocol bytes.
  localparam logic [7:0] BYTE_START = 8'h62;
  localparam logic [7:0] BYTE_READ  = 8'h72;
  localparam logic [7:0] BYTE_WRITE = 8'h77;
  localparam logic [7:0] BYTE_END   = 8'h66;
  localparam logic [7:0] BYTE_ERR   = 8'h65;
  localparam logic [7:0] BYTE_ZERO  = 8'h30;
  localparam logic [7:0] BYTE_NINE  = 8'h39;
  localparam logic [7:0] TGT_SETPT  = 8'h53;
  localparam logic [7:0] TGT_GAIN_P = 8'h50;
  localparam logic [7:0] TGT_GAIN_I = 8'h49;
  localparam logic [7:0] TGT_LED    = 8'h4C;
  localparam logic [7:0] TGT_VOLT   = 8'h56;
  localparam logic [7:0] TGT_OUTPUT = 8'h4F;

  localparam logic [1:0] WT_NONE     = 2'd0;
  localparam logic [1:0] WT_SETPOINT = 2'd1;
  localparam logic [1:0] WT_GAIN_P   = 2'd2;
  localparam logic [1:0] WT_GAIN_I   = 2'd3;

  typedef enum logic [2:0] {
    ERR_START   = 3'd1,
    ERR_COMMAND = 3'd2,
    ERR_WR_TGT  = 3'd3,
    ERR_VALUE   = 3'd4,
    ERR_RD_TGT  = 3'd5,
    ERR_TIMEOUT = 3'd6
  } sspc_err_t;

  localparam logic [13:0] SETPT_MIN   = 14'd80;
  localparam logic [13:0] SETPT_MAX   = 14'd240;
  localparam logic [13:0] CLAMP_3DIG  = 14'd999;
  localparam logic [13:0] CLAMP_4DIG  = 14'd9999;

  // Work handed from the parser to the reply generator.
  typedef enum logic [2:0] {
    JOB_END,
    JOB_ERR,
    JOB_SP_WRITE,
    JOB_SCALED_READ,
    JOB_GAIN_READ
  } sspc_job_kind_t;

  typedef enum logic [1:0] {
    SC_SP_WRITE,
    SC_SP_READ,
    SC_VOLTAGE,
    SC_OUTPUT
  } sspc_scale_t;

  typedef struct packed {
    sspc_job_kind_t kind;
    sspc_scale_t    scale;
    logic [13:0]    arg;
    logic [1:0]     wt;
    logic           clr;
    logic           led;
  } sspc_job_t;

  localparam int JOBQ_DEPTH = 4;
  localparam int JOBQ_AW    = $clog2(JOBQ_DEPTH);
  localparam int JOBQ_CW    = JOBQ_AW + 1;

  // Scaling is (a * mul + add) / div, with the division done as a multiply
  // by ceil(2^24 / div) and a shift; exact over every reachable numerator.
  localparam int RECIP_SHIFT = 24;
  localparam int NUM_W       = 17;
  localparam int RECIP_W     = 19;
  localparam int PROD_W      = NUM_W + RECIP_W;
  localparam int QUOT_W      = 12;

  typedef struct packed {
    logic [7:0]         mul;
    logic [6:0]         add;
    logic [RECIP_W-1:0] recip;
  } sspc_scale_k_t;

  function automatic sspc_scale_k_t scale_consts(sspc_scale_t s);
    sspc_scale_k_t k;
    case (s)
      SC_SP_WRITE: k = '{mul: 8'd136, add: 7'd25, recip: 19'd335545};
      SC_SP_READ:  k = '{mul: 8'd50,  add: 7'd68, recip: 19'd123362};
      SC_VOLTAGE:  k = '{mul: 8'd10,  add: 7'd41, recip: 19'd204601};
      default:     k = '{mul: 8'd100, add: 7'd0,  recip: 19'd61681};
    endcase
    return k;
  endfunction

  // Multiples of each decimal weight, most significant position first.
  localparam logic [13:0] DEC_MULT [0:3][0:9] = '{
    '{14'd0, 14'd1000, 14'd2000, 14'd3000, 14'd4000,
      14'd5000, 14'd6000, 14'd7000, 14'd8000, 14'd9000},
    '{14'd0, 14'd100, 14'd200, 14'd300, 14'd400,
      14'd500, 14'd600, 14'd700, 14'd800, 14'd900},
    '{14'd0, 14'd10, 14'd20, 14'd30, 14'd40,
      14'd50, 14'd60, 14'd70, 14'd80, 14'd90},
    '{14'd0, 14'd1, 14'd2, 14'd3, 14'd4,
      14'd5, 14'd6, 14'd7, 14'd8, 14'd9}
  };

  typedef struct packed {
    logic [3:0]  digit;
    logic [13:0] rest;
  } sspc_digit_t;

  // Peels off the digit at one decimal position with parallel compares.
  function automatic sspc_digit_t digit_split(logic [13:0] v, logic [1:0] pos);
    sspc_digit_t r;
    r.digit = 4'd0;
    r.rest  = v;
    for (int k = 1; k < 10; k++) begin
      if (v >= DEC_MULT[pos][k]) begin
        r.digit = 4'(k);
        r.rest  = v - DEC_MULT[pos][k];
      end
    end
    return r;
  endfunction

endpackage

// ===== sv/serial_setpoint_command_parser.sv =====
`timescale 1ns / 1ps
// Serial setpoint command parser, top level. Instantiates the parser front
// end, the job queue and the reply back end; depends on sspc_pkg.
//
// Usage: each input item is one received serial byte (command = 0) or a
// timeout event (command = 1), together with live voltage and process value
// samples used by voltage and output reads. The front end takes one item
// per cycle while the four-entry job queue has room; a finished command
// posts one job. The back end turns each job into 1 to 5 result items, one
// per cycle while out_ready is high, the final one marked with last.
// End and error replies and gain reads go from the fetched job straight to
// their bytes; setpoint write, setpoint read, voltage read and output read
// first pass through the scaling multiplier steps BK_MUL and BK_RECIP.
// The back end fetches a job only in its idle state, so it takes no new
// job until it has loaded the last byte of the current reply. A four-byte
// scaled read holds the back end longer than any other command.
// When the receiver stalls, the result register holds its item, the back
// end waits, and once the queue fills in_ready drops.
// Reset clears the command phase, the stored setpoint and gains, the
// indicator level, the queue and the result valid; no clearing pass needed.
module serial_setpoint_command_parser import sspc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  sspc_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output sspc_out_t out_data
);

  logic      fifo_push, fifo_pop, fifo_full, fifo_empty;
  sspc_job_t push_job, pop_job;

  sspc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .job_full (fifo_full),
    .job_push (fifo_push),
    .job_data (push_job)
  );

  sspc_job_fifo u_job_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (fifo_push),
    .push_job (push_job),
    .full     (fifo_full),
    .pop      (fifo_pop),
    .pop_job  (pop_job),
    .empty    (fifo_empty)
  );

  sspc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_empty (fifo_empty),
    .job_data  (pop_job),
    .job_pop   (fifo_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // A job is never posted into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_push |-> !fifo_full)
    else $error("job queue overflow");

  // Stored-value updates only ride on the closing end byte of a reply.
  a_write_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.write_target != WT_NONE) |->
      out_data.last && (out_data.tx_byte == BYTE_END))
    else $error("write reported on a non-final reply byte");

  // Integrator clear belongs to gain writes only.
  a_clear_gain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.integrator_clear |->
      (out_data.write_target == WT_GAIN_P) || (out_data.write_target == WT_GAIN_I))
    else $error("integrator clear without a gain write");

  // A reply byte before the last one is a digit or the error marker.
  a_body_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |->
      ((out_data.tx_byte >= BYTE_ZERO) && (out_data.tx_byte <= BYTE_NINE)) ||
      (out_data.tx_byte == BYTE_ERR))
    else $error("unexpected byte in reply body");

  // No result is offered in the cycle after a reset cycle.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

// ===== sv/sspc_front.sv =====
`timescale 1ns / 1ps
// Command parser front end: tracks the command phase, collects digits and
// posts one reply job per finished command. Depends on sspc_pkg.
module sspc_front import sspc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  sspc_in_t  in_data,
  input  logic      job_full,
  output logic      job_push,
  output sspc_job_t job_data
);

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_CMD,
    PH_WSEL,
    PH_WSP,
    PH_WKP,
    PH_WKI,
    PH_RSEL
  } phase_t;

  phase_t      phase_r, phase_nxt, phase_eff;
  logic [2:0]  cnt_r, cnt_nxt, cnt_step;
  logic [13:0] acc_r, acc_nxt, acc_step;
  logic [13:0] gain_p_r, gain_p_nxt;
  logic [13:0] gain_i_r, gain_i_nxt;
  logic        led_r, led_nxt;
  logic        accept;
  logic        is_digit;
  logic [3:0]  digit;

  assign in_ready = !job_full;
  assign accept   = in_valid && in_ready;

  assign is_digit = (in_data.rx_byte >= BYTE_ZERO) && (in_data.rx_byte <= BYTE_NINE);
  assign digit    = 4'(in_data.rx_byte - BYTE_ZERO);
  assign acc_step = 14'(18'(acc_r) * 18'd10 + 18'(digit));
  assign cnt_step = cnt_r + 3'd1;
  assign phase_eff = (phase_r > PH_RSEL) ? PH_IDLE : phase_r;

  always_comb begin
    phase_nxt  = phase_eff;
    cnt_nxt    = cnt_r;
    acc_nxt    = acc_r;
    gain_p_nxt = gain_p_r;
    gain_i_nxt = gain_i_r;
    led_nxt    = led_r;
    job_push   = 1'b0;
    job_data   = '{kind: JOB_END, scale: SC_SP_WRITE, arg: 14'd0,
                   wt: WT_NONE, clr: 1'b0, led: 1'b0};

    if (accept) begin
      if (in_data.command) begin
        if (phase_eff != PH_IDLE) begin
          job_push      = 1'b1;
          job_data.kind = JOB_ERR;
          job_data.arg  = {11'd0, ERR_TIMEOUT};
          phase_nxt     = PH_IDLE;
        end
      end else begin
        unique case (phase_eff) inside
          PH_IDLE: begin
            if (in_data.rx_byte == BYTE_START) begin
              phase_nxt = PH_CMD;
            end else begin
              job_push      = 1'b1;
              job_data.kind = JOB_ERR;
              job_data.arg  = {11'd0, ERR_START};
            end
          end
          PH_CMD: begin
            if (in_data.rx_byte == BYTE_READ) begin
              phase_nxt = PH_RSEL;
            end else if (in_data.rx_byte == BYTE_WRITE) begin
              phase_nxt = PH_WSEL;
              cnt_nxt   = 3'd0;
              acc_nxt   = 14'd0;
            end else begin
              job_push      = 1'b1;
              job_data.kind = JOB_ERR;
              job_data.arg  = {11'd0, ERR_COMMAND};
              phase_nxt     = PH_IDLE;
            end
          end
          PH_WSEL: begin
            unique case (in_data.rx_byte)
              TGT_SETPT:  phase_nxt = PH_WSP;
              TGT_GAIN_P: phase_nxt = PH_WKP;
              TGT_GAIN_I: phase_nxt = PH_WKI;
              TGT_LED: begin
                led_nxt   = !led_r;
                job_push  = 1'b1;
                phase_nxt = PH_IDLE;
              end
              default: begin
                job_push      = 1'b1;
                job_data.kind = JOB_ERR;
                job_data.arg  = {11'd0, ERR_WR_TGT};
                phase_nxt     = PH_IDLE;
              end
            endcase
          end
          PH_WSP, PH_WKP, PH_WKI: begin
            if (!is_digit) begin
              job_push      = 1'b1;
              job_data.kind = JOB_ERR;
              job_data.arg  = {11'd0, ERR_VALUE};
              phase_nxt     = PH_IDLE;
            end else begin
              acc_nxt = acc_step;
              cnt_nxt = cnt_step;
              if (phase_eff == PH_WSP) begin
                if (cnt_step >= 3'd3) begin
                  job_push  = 1'b1;
                  phase_nxt = PH_IDLE;
                  if (acc_step < SETPT_MIN || acc_step > SETPT_MAX) begin
                    job_data.kind = JOB_ERR;
                    job_data.arg  = {11'd0, ERR_VALUE};
                  end else begin
                    // The scaled value is worked out in the back end.
                    job_data.kind  = JOB_SP_WRITE;
                    job_data.scale = SC_SP_WRITE;
                    job_data.arg   = acc_step;
                    job_data.wt    = WT_SETPOINT;
                  end
                end
              end else if (cnt_step >= 3'd4) begin
                job_push     = 1'b1;
                phase_nxt    = PH_IDLE;
                job_data.arg = acc_step;
                job_data.clr = 1'b1;
                if (phase_eff == PH_WKP) begin
                  gain_p_nxt  = acc_step;
                  job_data.wt = WT_GAIN_P;
                end else begin
                  gain_i_nxt  = acc_step;
                  job_data.wt = WT_GAIN_I;
                end
              end
            end
          end
          PH_RSEL: begin
            job_push  = 1'b1;
            phase_nxt = PH_IDLE;
            unique case (in_data.rx_byte)
              TGT_SETPT: begin
                job_data.kind  = JOB_SCALED_READ;
                job_data.scale = SC_SP_READ;
              end
              TGT_GAIN_P: begin
                job_data.kind = JOB_GAIN_READ;
                job_data.arg  = gain_p_r;
              end
              TGT_GAIN_I: begin
                job_data.kind = JOB_GAIN_READ;
                job_data.arg  = gain_i_r;
              end
              TGT_VOLT: begin
                job_data.kind  = JOB_SCALED_READ;
                job_data.scale = SC_VOLTAGE;
                job_data.arg   = {4'd0, in_data.input_voltage};
              end
              TGT_OUTPUT: begin
                job_data.kind  = JOB_SCALED_READ;
                job_data.scale = SC_OUTPUT;
                job_data.arg   = {4'd0, in_data.process_value};
              end
              default: begin
                job_data.kind = JOB_ERR;
                job_data.arg  = {11'd0, ERR_RD_TGT};
              end
            endcase
          end
          default: phase_nxt = PH_IDLE;
        endcase
      end
    end
    // Every reply byte carries the indicator level after this item.
    job_data.led = led_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      cnt_r    <= 3'd0;
      acc_r    <= 14'd0;
      gain_p_r <= 14'd0;
      gain_i_r <= 14'd0;
      led_r    <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
      acc_r    <= acc_nxt;
      gain_p_r <= gain_p_nxt;
      gain_i_r <= gain_i_nxt;
      led_r    <= led_nxt;
    end
  end

endmodule

// ===== sv/sspc_job_fifo.sv =====
`timescale 1ns / 1ps
// Short job queue between the parser front end and the reply back end.
// Depends on sspc_pkg for the job type and depth.
module sspc_job_fifo import sspc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  sspc_job_t push_job,
  output logic      full,
  input  logic      pop,
  output sspc_job_t pop_job,
  output logic      empty
);

  sspc_job_t            slots_r [JOBQ_DEPTH];
  logic [JOBQ_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [JOBQ_CW-1:0]   count_r;

  assign full    = (count_r == JOBQ_CW'(JOBQ_DEPTH));
  assign empty   = (count_r == '0);
  assign pop_job = slots_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + JOBQ_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + JOBQ_AW'(1);
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + JOBQ_CW'(1);
        2'b01:   count_r <= count_r - JOBQ_CW'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ===== sv/sspc_back.sv =====
`timescale 1ns / 1ps
// Reply back end: scales values, splits them into decimal digits and drives
// the registered result channel. Depends on sspc_pkg.
module sspc_back import sspc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      job_empty,
  input  sspc_job_t job_data,
  output logic      job_pop,
  output logic      out_valid,
  input  logic      out_ready,
  output sspc_out_t out_data
);

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_RECIP,
    BK_DIGIT,
    BK_END,
    BK_ERR,
    BK_ERR_CODE
  } back_state_t;

  back_state_t        state_r, state_nxt;
  sspc_job_t          job_r, job_nxt;
  logic [NUM_W-1:0]   num_r, num_nxt;
  logic [13:0]        value_r, value_nxt;
  logic [1:0]         pos_r, pos_nxt;
  logic [9:0]         setpt_r, setpt_nxt;
  logic               out_valid_r, out_valid_nxt;
  sspc_out_t          out_r, out_nxt;

  logic               load;
  sspc_scale_k_t      kc;
  logic [13:0]        scale_arg;
  logic [PROD_W-1:0]  prod;
  logic [QUOT_W-1:0]  quot;
  sspc_digit_t        dsplit;

  assign load      = !out_valid_r || out_ready;
  assign job_pop   = (state_r == BK_IDLE) && !job_empty;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign kc        = scale_consts(job_r.scale);
  assign scale_arg = (job_r.scale == SC_SP_READ) ? {4'd0, setpt_r} : job_r.arg;
  assign prod      = PROD_W'(num_r) * PROD_W'(kc.recip);
  assign quot      = prod[RECIP_SHIFT +: QUOT_W];
  assign dsplit    = digit_split(value_r, pos_r);

  always_comb begin
    state_nxt     = state_r;
    job_nxt       = job_r;
    num_nxt       = num_r;
    value_nxt     = value_r;
    pos_nxt       = pos_r;
    setpt_nxt     = setpt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;

    unique case (state_r)
      BK_IDLE: begin
        if (!job_empty) begin
          job_nxt = job_data;
          unique case (job_data.kind) inside
            JOB_END:                       state_nxt = BK_END;
            JOB_ERR:                       state_nxt = BK_ERR;
            JOB_SP_WRITE, JOB_SCALED_READ: state_nxt = BK_MUL;
            JOB_GAIN_READ: begin
              value_nxt = (job_data.arg > CLAMP_4DIG) ? CLAMP_4DIG : job_data.arg;
              pos_nxt   = 2'd0;
              state_nxt = BK_DIGIT;
            end
            default:                       state_nxt = BK_IDLE;
          endcase
        end
      end
      BK_MUL: begin
        num_nxt   = NUM_W'(22'(scale_arg) * 22'(kc.mul)) + NUM_W'(kc.add);
        state_nxt = BK_RECIP;
      end
      BK_RECIP: begin
        if (job_r.kind == JOB_SP_WRITE) begin
          setpt_nxt = quot[9:0];
          value_nxt = {4'd0, quot[9:0]};
          state_nxt = BK_END;
        end else begin
          value_nxt = (14'(quot) > CLAMP_3DIG) ? CLAMP_3DIG : 14'(quot);
          pos_nxt   = 2'd1;
          state_nxt = BK_DIGIT;
        end
      end
      BK_DIGIT: begin
        if (load) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{tx_byte: BYTE_ZERO + {4'd0, dsplit.digit}, last: 1'b0,
                            write_target: WT_NONE, write_value: 14'd0,
                            integrator_clear: 1'b0, led_level: job_r.led};
          value_nxt     = dsplit.rest;
          pos_nxt       = pos_r + 2'd1;
          if (pos_r == 2'd3) begin
            state_nxt = BK_END;
          end
        end
      end
      BK_END: begin
        if (load) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{tx_byte: BYTE_END, last: 1'b1, write_target: job_r.wt,
                            write_value: 14'd0, integrator_clear: job_r.clr,
                            led_level: job_r.led};
          if (job_r.wt != WT_NONE) begin
            out_nxt.write_value = (job_r.kind == JOB_SP_WRITE) ? value_r : job_r.arg;
          end
          state_nxt = BK_IDLE;
        end
      end
      BK_ERR: begin
        if (load) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{tx_byte: BYTE_ERR, last: 1'b0, write_target: WT_NONE,
                            write_value: 14'd0, integrator_clear: 1'b0,
                            led_level: job_r.led};
          state_nxt     = BK_ERR_CODE;
        end
      end
      BK_ERR_CODE: begin
        if (load) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{tx_byte: BYTE_ZERO + {5'd0, job_r.arg[2:0]}, last: 1'b1,
                            write_target: WT_NONE, write_value: 14'd0,
                            integrator_clear: 1'b0, led_level: job_r.led};
          state_nxt     = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      setpt_r     <= 10'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      setpt_r     <= setpt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    job_r   <= job_nxt;
    num_r   <= num_nxt;
    value_r <= value_nxt;
    pos_r   <= pos_nxt;
    out_r   <= out_nxt;
  end

endmodule
